>>> rtl/core/adsr_envelope_generator_assert.svh
// Assertion macros used by the checker file.
`ifndef ADSR_ENVELOPE_GENERATOR_ASSERT_SVH
`define ADSR_ENVELOPE_GENERATOR_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define ADSR_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("adsr: same-cycle property failed");

// Next-cycle implication, off while reset is asserted.
`define ADSR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("adsr: next-cycle property failed");

// Next-cycle implication that is also checked through reset.
`define ADSR_ASSERT_NEXT_NORST(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("adsr: reset property failed");

`endif

>>> rtl/core/adsr_pkg.sv
package adsr_pkg;

    localparam int TIME_W     = 32;
    localparam int SUST_W     = 16;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int PHASE_W    = 3;

    typedef enum logic [PHASE_W-1:0] {
        PH_ATTACK   = 3'd0,
        PH_DECAY    = 3'd1,
        PH_SUSTAIN  = 3'd2,
        PH_RELEASE  = 3'd3,
        PH_FINISHED = 3'd4
    } phase_t;

    localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP    = 3'd4;

    typedef struct packed {
        logic [TIME_W-1:0] attack_time;
        logic [TIME_W-1:0] decay_time;
        logic [SUST_W-1:0] sustain_level;
        logic [TIME_W-1:0] release_time;
        logic [TIME_W-1:0] ms_per_sample;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        attack_time:   32'd655360,
        decay_time:    32'd6553600,
        sustain_level: 16'd32768,
        release_time:  32'd6553600,
        ms_per_sample: 32'd1365
    };

    // controller -> datapath
    typedef struct packed {
        logic update;     // edge handling and position advance
        logic prep;       // load divider operands
        logic div_step;   // one quotient bit
        logic mul_sq;     // g * g
        logic mul_scale;  // span * (g * g)
        logic load_out;   // capture result beat
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic skip_div;   // quotient known without dividing
    } stat_t;

endpackage

>>> rtl/core/adsr_regs.sv
module adsr_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wen,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [adsr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output adsr_pkg::cfg_t                   cfg
);
    import adsr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wen) begin
            case (cfg_index)
                REG_ATTACK:  cfg_next.attack_time   = cfg_wdata;
                REG_DECAY:   cfg_next.decay_time    = cfg_wdata;
                REG_SUSTAIN: cfg_next.sustain_level = cfg_wdata[SUST_W-1:0];
                REG_RELEASE: cfg_next.release_time  = cfg_wdata;
                REG_STEP:    cfg_next.ms_per_sample = cfg_wdata;
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/adsr_ctrl.sv
module adsr_ctrl #(
    parameter int LEVEL_BITS = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    input  adsr_pkg::stat_t stat,
    output adsr_pkg::cmd_t  cmd
);
    import adsr_pkg::*;

    localparam int CNT_W = $clog2(LEVEL_BITS);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(LEVEL_BITS - 2);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_SQ,
        ST_SCALE,
        ST_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic             accept;
    logic             out_free;

    always_comb begin
        s_ready  = (state_reg == ST_IDLE);
        accept   = s_valid && s_ready;
        out_free = !m_valid_reg || m_ready;

        cmd           = '0;
        cmd.update    = accept;
        cmd.prep      = (state_reg == ST_PREP);
        cmd.div_step  = (state_reg == ST_DIV);
        cmd.mul_sq    = (state_reg == ST_SQ);
        cmd.mul_scale = (state_reg == ST_SCALE);
        cmd.load_out  = (state_reg == ST_DONE) && out_free;

        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) state_next = ST_PREP;
            end
            ST_PREP: begin
                cnt_next   = DIV_LAST;
                state_next = stat.skip_div ? ST_SQ : ST_DIV;
            end
            ST_DIV: begin
                if (cnt_reg == '0) state_next = ST_SQ;
                else               cnt_next   = cnt_reg - 1'b1;
            end
            ST_SQ:    state_next = ST_SCALE;
            ST_SCALE: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase

        if (cmd.load_out)  m_valid_next = 1'b1;
        else if (m_ready)  m_valid_next = 1'b0;
        else               m_valid_next = m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

>>> rtl/core/adsr_dp.sv
module adsr_dp #(
    parameter int LEVEL_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  adsr_pkg::cfg_t                 cfg,
    input  adsr_pkg::cmd_t                 cmd,
    output adsr_pkg::stat_t                stat,
    input  logic                           s_gate,
    output logic [LEVEL_BITS-1:0]          m_level,
    output logic [adsr_pkg::PHASE_W-1:0]   m_phase
);
    import adsr_pkg::*;

    localparam int L  = LEVEL_BITS;
    localparam int PW = 2 * LEVEL_BITS;
    localparam int CW = (LEVEL_BITS > SUST_W) ? LEVEL_BITS : SUST_W;
    localparam logic [L-1:0]  ONE_L  = {1'b1, {(L-1){1'b0}}};
    localparam logic [CW-1:0] ONE_CW = CW'(ONE_L);

    // envelope state
    phase_t             phase_reg, phase_next;
    logic [TIME_W-1:0]  pos_reg, pos_next;
    logic               gate_reg;
    logic [L-1:0]       prev_lvl_reg;
    logic [L-1:0]       rsl_reg, rsl_next;

    // working registers
    logic [TIME_W:0]    rem_reg;
    logic [TIME_W-1:0]  dsr_reg;
    logic [L-1:0]       quot_reg;
    logic [PW-1:0]      prod_reg;
    logic [L-1:0]       level_reg;
    logic [PHASE_W-1:0] phase_out_reg;

    function automatic logic [TIME_W-1:0] dur_of(input phase_t ph, input cfg_t c);
        logic [TIME_W-1:0] d;
        case (ph)
            PH_ATTACK:  d = c.attack_time;
            PH_DECAY:   d = c.decay_time;
            PH_RELEASE: d = c.release_time;
            default:    d = '0;
        endcase
        return d;
    endfunction

    // gate edge, then position advance
    phase_t            ph_edge;
    logic [TIME_W-1:0] pos_edge;
    logic [TIME_W-1:0] adv_dur;
    logic [TIME_W:0]   sum;
    logic              reached;

    always_comb begin
        ph_edge  = phase_reg;
        pos_edge = pos_reg;
        rsl_next = rsl_reg;
        if (s_gate != gate_reg) begin
            if (s_gate) begin
                ph_edge = PH_ATTACK;
            end else begin
                rsl_next = prev_lvl_reg;
                ph_edge  = (cfg.release_time != '0) ? PH_RELEASE : PH_FINISHED;
            end
            pos_edge = '0;
        end

        adv_dur = dur_of(ph_edge, cfg);
        sum     = {1'b0, pos_edge} + {1'b0, cfg.ms_per_sample};
        reached = sum[TIME_W] || (sum >= {1'b0, adv_dur});

        phase_next = ph_edge;
        pos_next   = pos_edge;
        case (ph_edge)
            PH_ATTACK, PH_DECAY, PH_RELEASE: begin
                if (reached) begin
                    pos_next = '0;
                    case (ph_edge)
                        PH_ATTACK: phase_next = (cfg.decay_time != '0) ? PH_DECAY
                                                                      : PH_SUSTAIN;
                        PH_DECAY:  phase_next = PH_SUSTAIN;
                        default:   phase_next = PH_FINISHED;
                    endcase
                end else begin
                    pos_next = sum[TIME_W-1:0];
                end
            end
            default: pos_next = pos_edge;
        endcase
    end

    // divider operands: attack pos/T, fall (T-pos)/T, both scaled by ONE
    logic [TIME_W-1:0] dur_p;
    logic [TIME_W-1:0] rem0;
    logic              over;
    logic              skip;
    logic [L-1:0]      byp;

    always_comb begin
        dur_p = dur_of(phase_reg, cfg);
        over  = (dur_p == '0) || (pos_reg >= dur_p);
        case (phase_reg)
            PH_ATTACK: begin
                skip = over;
                byp  = over ? ONE_L : '0;
                rem0 = pos_reg;
            end
            PH_DECAY, PH_RELEASE: begin
                // position zero gives exactly full scale
                skip = over || (pos_reg == '0);
                byp  = over ? '0 : ONE_L;
                rem0 = dur_p - pos_reg;
            end
            default: begin
                skip = 1'b1;
                byp  = '0;
                rem0 = '0;
            end
        endcase
        stat.skip_div = skip;
    end

    // restoring divide, one bit per step
    logic [TIME_W:0] rem_sh;
    logic            ge;
    logic [TIME_W:0] rem_step;

    always_comb begin
        rem_sh   = {rem_reg[TIME_W-1:0], 1'b0};
        ge       = rem_sh >= {1'b0, dsr_reg};
        rem_step = ge ? (rem_sh - {1'b0, dsr_reg}) : rem_sh;
    end

    // shared multiplier
    logic [CW-1:0] sus_ext;
    logic [L-1:0]  s_lvl;
    logic [L-1:0]  frac;
    logic [L-1:0]  scale_a;
    logic [L-1:0]  mul_a, mul_b;
    logic [PW-1:0] prod_c;
    logic [L-1:0]  level_c;

    always_comb begin
        sus_ext = CW'(cfg.sustain_level);
        s_lvl   = (sus_ext > ONE_CW) ? ONE_L : sus_ext[L-1:0];
        frac    = prod_reg[PW-2:L-1];
        scale_a = (phase_reg == PH_DECAY) ? (ONE_L - s_lvl) : rsl_reg;
        mul_a   = cmd.mul_sq ? quot_reg : scale_a;
        mul_b   = cmd.mul_sq ? quot_reg : frac;
        prod_c  = PW'(mul_a) * PW'(mul_b);

        case (phase_reg)
            PH_ATTACK:  level_c = quot_reg;
            PH_DECAY:   level_c = s_lvl + frac;
            PH_SUSTAIN: level_c = s_lvl;
            PH_RELEASE: level_c = frac;
            default:    level_c = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_FINISHED;
            pos_reg      <= '0;
            gate_reg     <= 1'b0;
            prev_lvl_reg <= '0;
            rsl_reg      <= '0;
        end else begin
            if (cmd.update) begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                gate_reg  <= s_gate;
                rsl_reg   <= rsl_next;
            end
            if (cmd.load_out) prev_lvl_reg <= level_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            rem_reg  <= {1'b0, rem0};
            dsr_reg  <= dur_p;
            quot_reg <= skip ? byp : '0;
        end
        if (cmd.div_step) begin
            rem_reg  <= rem_step;
            quot_reg <= {quot_reg[L-2:0], ge};
        end
        if (cmd.mul_sq || cmd.mul_scale) prod_reg <= prod_c;
        if (cmd.load_out) begin
            level_reg     <= level_c;
            phase_out_reg <= phase_reg;
        end
    end

    assign m_level = level_reg;
    assign m_phase = phase_out_reg;

endmodule

>>> rtl/core/adsr_envelope_generator.sv
// ADSR envelope generator. Each s_ beat is one sample tick carrying the gate
// level; each m_ beat returns that sample's envelope level (Q1.15 style,
// full scale = 2^(LEVEL_BITS-1)) and phase (0 attack, 1 decay, 2 sustain,
// 3 release, 4 finished). A rising gate restarts attack from zero, a falling
// gate latches the last level and starts release (or goes silent when the
// release time is zero). Times and the per-tick step share one unsigned
// fixed-point format; only their ratios matter. Attack is linear, decay and
// release fall along (1-t/T)^2. A new tick is accepted only once the previous
// one has left the sequencer. The bit-serial divider forms the position/duration
// ratio one quotient bit per clock; when the ratio is known outright (sustain,
// finished, decay or release start, degenerate durations) the divider is
// skipped. The result sits in an output register, so the next tick is
// accepted while the previous result still waits on m_ready. Configuration
// is a plain write port (cfg_wen/cfg_index/cfg_wdata): index 0 attack time,
// 1 decay time, 2 sustain level, 3 release time, 4 step per tick; other
// indexes are ignored. Write configuration only while no beat is in flight.
module adsr_envelope_generator #(
    parameter int LEVEL_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // sample ticks
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_gate,
    // envelope results
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [LEVEL_BITS-1:0]           m_level,
    output logic [adsr_pkg::PHASE_W-1:0]    m_phase,
    // configuration writes
    input  logic                            cfg_wen,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [adsr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import adsr_pkg::*;

    cfg_t  cfg;
    cmd_t  cmd;
    stat_t stat;

    // register file
    adsr_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // sequencer: accept, prep, divide, square, scale, deliver
    adsr_ctrl #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // envelope state, divider, multiplier, output register
    adsr_dp #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .cmd     (cmd),
        .stat    (stat),
        .s_gate  (s_gate),
        .m_level (m_level),
        .m_phase (m_phase)
    );

endmodule

>>> rtl/core/adsr_chk.sv
`include "adsr_envelope_generator_assert.svh"

module adsr_chk #(
    parameter int LEVEL_BITS = 16
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [LEVEL_BITS-1:0]         m_level,
    input logic [adsr_pkg::PHASE_W-1:0]  m_phase
);
    import adsr_pkg::*;

    localparam logic [LEVEL_BITS-1:0] ONE_L = {1'b1, {(LEVEL_BITS-1){1'b0}}};

    // no result beat right after reset
    `ADSR_ASSERT_NEXT_NORST(a_reset_idle, aclk, !aresetn, !m_valid)
    // stalled result beat holds
    `ADSR_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_level) && $stable(m_phase))
    // level within full scale, phase code in use
    `ADSR_ASSERT_IMPLY(a_range, aclk, aresetn, m_valid, m_level <= ONE_L && m_phase <= PH_FINISHED)
    // finished envelope is silent
    `ADSR_ASSERT_IMPLY(a_silent, aclk, aresetn, m_valid && m_phase == PH_FINISHED, m_level == '0)

endmodule

bind adsr_envelope_generator adsr_chk #(
    .LEVEL_BITS (LEVEL_BITS)
) u_adsr_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_level (m_level),
    .m_phase (m_phase)
);
